// ===== rtl/three_band_biquad_equalizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-band biquad equalizer
// Shared helpers that wrap concurrent assertions on the block clock.
// ----------------------------------------------------------------------------
`ifndef THREE_BAND_BIQUAD_EQUALIZER_UNIT_MACROS_SVH
`define THREE_BAND_BIQUAD_EQUALIZER_UNIT_MACROS_SVH

// Checked outside reset only
`define EQZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included
`define EQZ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/eqz_pkg.sv =====
// ----------------------------------------------------------------------------
// eqz_pkg
// Shared constants, register codes and control types of the equalizer.
// ----------------------------------------------------------------------------
package eqz_pkg;

  // Default configuration
  localparam int CHANNELS_DEF       = 2;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Fixed geometry
  localparam int NUM_BANDS  = 3;
  localparam int COEF_BITS  = 20;
  localparam int FF_BITS    = 3 * COEF_BITS;
  localparam int FB_BITS    = 2 * COEF_BITS;
  localparam int CFG_DATA_W = FF_BITS;
  localparam int CFG_IDX_W  = 3;

  // Register reset values: b0 = 1.0, everything else zero
  localparam logic [FF_BITS-1:0] FF_RESET = FF_BITS'(65536);
  localparam logic [FB_BITS-1:0] FB_RESET = '0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_ENABLE = 3'd0,
    REG_BASS_FF     = 3'd1,
    REG_BASS_FB     = 3'd2,
    REG_MID_FF      = 3'd3,
    REG_MID_FB      = 3'd4,
    REG_TREBLE_FF   = 3'd5,
    REG_TREBLE_FB   = 3'd6
  } eqz_reg_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // register a new product
    logic sub;     // product is a feedback term
  } eqz_mac_ctrl_t;

endpackage

// ===== rtl/eqz_in_if.sv =====
// ----------------------------------------------------------------------------
// eqz_in_if
// Input sample channel: valid/ready handshake with sample, channel, marker.
// ----------------------------------------------------------------------------
interface eqz_in_if #(
  parameter int SAMPLE_BITS = eqz_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel_in;
  logic                          frame_end_in;

  modport source (output valid, sample_in, channel_in, frame_end_in, input ready);
  modport sink   (input valid, sample_in, channel_in, frame_end_in, output ready);
endinterface

// ===== rtl/eqz_out_if.sv =====
// ----------------------------------------------------------------------------
// eqz_out_if
// Output sample channel: valid/ready handshake with sample, channel, marker.
// ----------------------------------------------------------------------------
interface eqz_out_if #(
  parameter int SAMPLE_BITS = eqz_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  logic                          frame_end_out;

  modport source (output valid, sample_out, channel_out, frame_end_out, input ready);
  modport sink   (input valid, sample_out, channel_out, frame_end_out, output ready);
endinterface

// ===== rtl/eqz_hist_mem.sv =====
// ----------------------------------------------------------------------------
// eqz_hist_mem
// Filter history memory: one row of x1, x2, y1, y2 per channel and band.
// Synchronous read, data in the next cycle; unwritten rows read as zero.
// ----------------------------------------------------------------------------
module eqz_hist_mem #(
  parameter int CHANNELS    = eqz_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = eqz_pkg::SAMPLE_BITS_DEF,
  localparam int DEPTH      = CHANNELS * eqz_pkg::NUM_BANDS,
  localparam int AW         = $clog2(DEPTH),
  localparam int ROW_W      = 4 * SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_q;
  logic [DEPTH-1:0] row_valid;
  logic             rd_hit;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Per-row written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

// ===== rtl/eqz_mac.sv =====
// ----------------------------------------------------------------------------
// eqz_mac
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// One registered product per cycle while enabled, accumulated the cycle after.
// ----------------------------------------------------------------------------
module eqz_mac #(
  parameter int SAMPLE_BITS    = eqz_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = eqz_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  eqz_pkg::eqz_mac_ctrl_t        ctrl,
  input  logic signed [eqz_pkg::COEF_BITS-1:0] coef,
  input  logic signed [SAMPLE_BITS-1:0] opnd,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = eqz_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RW     = ACC_W + 1;
  localparam logic signed [RW-1:0] RND    = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = (RW'(1) << (SAMPLE_BITS - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_sub;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [RW-1:0]     rounded;
  logic signed [RW-1:0]     shifted;

  // Product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * opnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      prod_sub <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul_en;
      prod_sub <= ctrl.sub;
    end
  end

  // Accumulator
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
    end
  end

  // Round half up, drop fraction bits, clamp to sample range
  always_comb begin
    rounded = RW'(acc) + RND;
    shifted = rounded >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/three_band_biquad_equalizer_unit.sv =====
// ----------------------------------------------------------------------------
// three_band_biquad_equalizer_unit
// Bass, mid and treble direct-form-I biquads in cascade over interleaved
// channels; per-channel history lives in a single-port-style row memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries one sample with its channel and a buffer-end marker;
//   out_stream returns one equalized sample per input transaction, in order,
//   with channel and marker passed through. Coefficients and band enables are
//   written through cfg_write/cfg_index/cfg_data while the block is idle.
// Sequencing:
//   One sample at a time. Each enabled band costs one history read, five
//   products through the one shared multiplier, one accumulate drain and
//   one write-back. A channel outside the configured range passes straight
//   through.
// Reset:
//   Synchronous, active high. Registers return to unity-gain pass-through
//   with all bands disabled; history rows read as zero until written.
// Back-pressure:
//   The result sits in an output register; a new sample is taken while it
//   waits, but the next result is held until out_stream.ready frees it.
// ----------------------------------------------------------------------------
`include "three_band_biquad_equalizer_unit_macros.svh"

module three_band_biquad_equalizer_unit #(
  parameter int CHANNELS       = eqz_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = eqz_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = eqz_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  eqz_in_if.sink                         in_stream,
  eqz_out_if.source                      out_stream,
  input  logic                           cfg_write,
  input  logic [eqz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eqz_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = CHANNELS * eqz_pkg::NUM_BANDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROW_W = 4 * SAMPLE_BITS;
  localparam int CB    = eqz_pkg::COEF_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MAC  = 6'b000100,
    S_ACC  = 6'b001000,
    S_WB   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    T_X0 = 3'd0,
    T_X1 = 3'd1,
    T_X2 = 3'd2,
    T_Y1 = 3'd3,
    T_Y2 = 3'd4
  } term_t;

  // Configuration registers
  logic [eqz_pkg::NUM_BANDS-1:0] band_enable;
  logic [eqz_pkg::FF_BITS-1:0]   ff [eqz_pkg::NUM_BANDS];
  logic [eqz_pkg::FB_BITS-1:0]   fb [eqz_pkg::NUM_BANDS];

  // Sequencer and item registers
  state_t                        state, state_next;
  term_t                         term, term_next;
  logic [1:0]                    band;
  logic signed [SAMPLE_BITS-1:0] x0;
  logic                          ch;
  logic                          frame_end;

  // Output register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_channel;
  logic                          out_frame_end;

  // Datapath nets
  logic                          in_acc;
  logic                          ch_ok;
  logic                          bands_done;
  logic                          out_load;
  logic                          hist_re;
  logic                          hist_we;
  logic [AW-1:0]                 hist_addr;
  logic [ROW_W-1:0]              hist_row;
  logic [ROW_W-1:0]              hist_wr_row;
  logic signed [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
  logic [eqz_pkg::FF_BITS-1:0]   ff_sel;
  logic [eqz_pkg::FB_BITS-1:0]   fb_sel;
  logic signed [CB-1:0]          coef;
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [SAMPLE_BITS-1:0] y0;
  eqz_pkg::eqz_mac_ctrl_t        mac_ctrl;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      band_enable <= '0;
      for (int b = 0; b < eqz_pkg::NUM_BANDS; b++) begin
        ff[b] <= eqz_pkg::FF_RESET;
        fb[b] <= eqz_pkg::FB_RESET;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        eqz_pkg::REG_BAND_ENABLE: band_enable <= cfg_data[eqz_pkg::NUM_BANDS-1:0];
        eqz_pkg::REG_BASS_FF:     ff[0] <= cfg_data[eqz_pkg::FF_BITS-1:0];
        eqz_pkg::REG_BASS_FB:     fb[0] <= cfg_data[eqz_pkg::FB_BITS-1:0];
        eqz_pkg::REG_MID_FF:      ff[1] <= cfg_data[eqz_pkg::FF_BITS-1:0];
        eqz_pkg::REG_MID_FB:      fb[1] <= cfg_data[eqz_pkg::FB_BITS-1:0];
        eqz_pkg::REG_TREBLE_FF:   ff[2] <= cfg_data[eqz_pkg::FF_BITS-1:0];
        eqz_pkg::REG_TREBLE_FB:   fb[2] <= cfg_data[eqz_pkg::FB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and status
  assign in_stream.ready = (state == S_IDLE);
  assign in_acc          = in_stream.valid && in_stream.ready;
  assign ch_ok           = int'(ch) < CHANNELS;
  assign bands_done      = (band == 2'(eqz_pkg::NUM_BANDS));
  assign out_load        = (state == S_DONE) && (!out_valid || out_stream.ready);

  // Next state
  always_comb begin
    state_next = state;
    term_next  = term;
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!ch_ok || bands_done) begin
          state_next = S_DONE;
        end else if (band_enable[band]) begin
          state_next = S_MAC;
          term_next  = T_X0;
        end
      end
      S_MAC: begin
        case (term)
          T_X0:    term_next = T_X1;
          T_X1:    term_next = T_X2;
          T_X2:    term_next = T_Y1;
          T_Y1:    term_next = T_Y2;
          default: term_next = T_X0;
        endcase
        if (term == T_Y2) state_next = S_ACC;
      end
      S_ACC:  state_next = S_WB;
      S_WB:   state_next = S_SCAN;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= T_X0;
      band  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      if (in_acc) begin
        band <= '0;
      end else if ((state == S_SCAN && !bands_done && ch_ok && !band_enable[band]) ||
                   state == S_WB) begin
        band <= band + 2'd1;
      end
    end
  end

  // Running sample: input on accept, each stage output after write-back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x0        <= in_stream.sample_in;
      ch        <= in_stream.channel_in;
      frame_end <= in_stream.frame_end_in;
    end else if (state == S_WB) begin
      x0 <= y0;
    end
  end

  // History row access; one item in flight, so a row is never read before
  // its previous write-back has landed
  assign hist_addr = AW'(int'(ch) * eqz_pkg::NUM_BANDS + int'(band));
  assign hist_re   = (state == S_SCAN) && ch_ok && !bands_done && band_enable[band];
  assign hist_we   = (state == S_WB);

  assign h_x1 = hist_row[SAMPLE_BITS-1:0];
  assign h_x2 = hist_row[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign h_y1 = hist_row[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign h_y2 = hist_row[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

  // Shifted history: x2 <= x1, x1 <= x0, y2 <= y1, y1 <= y0
  assign hist_wr_row = {h_y1, y0, h_x1, x0};

  eqz_hist_mem #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (hist_re),
    .rd_addr (hist_addr),
    .rd_data (hist_row),
    .wr_en   (hist_we),
    .wr_addr (hist_addr),
    .wr_data (hist_wr_row)
  );

  // Operand and coefficient select for the current term
  assign ff_sel = ff[band];
  assign fb_sel = fb[band];

  always_comb begin
    case (term)
      T_X0: begin
        coef = ff_sel[CB-1:0];
        opnd = x0;
      end
      T_X1: begin
        coef = ff_sel[2*CB-1:CB];
        opnd = h_x1;
      end
      T_X2: begin
        coef = ff_sel[3*CB-1:2*CB];
        opnd = h_x2;
      end
      T_Y1: begin
        coef = fb_sel[CB-1:0];
        opnd = h_y1;
      end
      T_Y2: begin
        coef = fb_sel[2*CB-1:CB];
        opnd = h_y2;
      end
      default: begin
        coef = '0;
        opnd = '0;
      end
    endcase
  end

  assign mac_ctrl.clear  = hist_re;
  assign mac_ctrl.mul_en = (state == S_MAC);
  assign mac_ctrl.sub    = (term == T_Y1) || (term == T_Y2);

  eqz_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef),
    .opnd   (opnd),
    .result (y0)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample    <= x0;
      out_channel   <= ch;
      out_frame_end <= frame_end;
    end
  end

  assign out_stream.valid         = out_valid;
  assign out_stream.sample_out    = out_sample;
  assign out_stream.channel_out   = out_channel;
  assign out_stream.frame_end_out = out_frame_end;

  // Checks
  `EQZ_ASSERT(a_no_rw_overlap, !(hist_re && hist_we), "history read and write in one cycle")
  `EQZ_ASSERT(a_accept_starts_scan, in_acc |=> (state == S_SCAN), "accept did not start a scan")
  `EQZ_ASSERT(a_wb_after_drain, (state == S_WB) |-> $past(state == S_ACC),
              "write-back without accumulator drain")
  `EQZ_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state == S_DONE),
              "result raised outside completion")
  `EQZ_ASSERT(a_state_onehot, $onehot(state), "sequencer state not one-hot")

endmodule

// ===== verif/tb_three_band_biquad_equalizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_three_band_biquad_equalizer_unit
// Self-checking bench for the three-band biquad equalizer. A driver and a
// monitor exchange valid/ready transactions with the block. A bit-accurate
// in-bench filter model, with its own copy of the registers and of the
// per-channel history, predicts every result, and results are compared
// field by field in order. Directed corner cases come first. Then come
// register settings with random coefficients and random sample streams,
// under changing idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_three_band_biquad_equalizer_unit;

  localparam int SB           = eqz_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC         = eqz_pkg::COEF_FRAC_BITS_DEF;
  localparam int CHANNELS_DEF = eqz_pkg::CHANNELS_DEF;
  localparam int NUM_BANDS    = eqz_pkg::NUM_BANDS;
  localparam int COEF_BITS    = eqz_pkg::COEF_BITS;
  localparam int FF_BITS      = eqz_pkg::FF_BITS;
  localparam int FB_BITS      = eqz_pkg::FB_BITS;
  localparam int CFG_DATA_W   = eqz_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W    = eqz_pkg::CFG_IDX_W;
  localparam int BASS      = 0;
  localparam int MID       = 1;
  localparam int TREBLE    = 2;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 115;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam longint RUN_LIMIT = 4_000_000;

  // Register index past the end of the map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_MAX  = 20'h7FFFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN  = 20'h80000;
  localparam logic [COEF_BITS-1:0] COEF_ONE  = 20'h10000;
  localparam logic [COEF_BITS-1:0] COEF_HALF = 20'h08000;
  localparam logic [COEF_BITS-1:0] COEF_LSB  = 20'h00001;
  localparam logic [COEF_BITS-1:0] COEF_ZERO = 20'h00000;

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 channel;
    logic                 frame_end;
  } eq_sample_t;

  typedef struct {
    logic signed [SB-1:0] x1;
    logic signed [SB-1:0] x2;
    logic signed [SB-1:0] y1;
    logic signed [SB-1:0] y2;
  } stage_hist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  eqz_in_if  in_bus ();
  eqz_out_if out_bus ();

  three_band_biquad_equalizer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_bus),
    .out_stream (out_bus),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter model state: register copies and per-channel, per-band history
  logic [2:0]         band_en_m;
  logic [FF_BITS-1:0] ff_m [NUM_BANDS];
  logic [FB_BITS-1:0] fb_m [NUM_BANDS];
  stage_hist_t        hist [CHANNELS_DEF][NUM_BANDS];

  eq_sample_t samples_to_send [$];
  eq_sample_t equalized_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_armed = 1'b0;
  logic        out_hold = 1'b0;

  int failures       = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int frame_ends     = 0;
  int clipped_stages = 0;
  int settings_n     = 0;

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic longint coef_of(logic [FF_BITS-1:0] word, int slot);
    logic signed [COEF_BITS-1:0] c;
    c = word[slot*COEF_BITS +: COEF_BITS];
    return longint'(c);
  endfunction

  // Cascade the enabled bands; round half up, clip each stage to SB bits
  function automatic eq_sample_t equalize_sample(eq_sample_t in_s);
    eq_sample_t           res;
    logic signed [SB-1:0] s;
    longint               acc;
    int                   ch;
    res = in_s;
    s   = in_s.sample;
    ch  = int'(in_s.channel);
    if (ch < CHANNELS_DEF) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        if (band_en_m[b]) begin
          acc = coef_of(ff_m[b], 0) * longint'(s)
              + coef_of(ff_m[b], 1) * longint'(hist[ch][b].x1)
              + coef_of(ff_m[b], 2) * longint'(hist[ch][b].x2)
              - coef_of(FF_BITS'(fb_m[b]), 0) * longint'(hist[ch][b].y1)
              - coef_of(FF_BITS'(fb_m[b]), 1) * longint'(hist[ch][b].y2);
          acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
          if (acc > longint'(SAMPLE_MAX)) begin
            acc = longint'(SAMPLE_MAX);
            clipped_stages++;
          end else if (acc < longint'(SAMPLE_MIN)) begin
            acc = longint'(SAMPLE_MIN);
            clipped_stages++;
          end
          hist[ch][b].x2 = hist[ch][b].x1;
          hist[ch][b].x1 = s;
          hist[ch][b].y2 = hist[ch][b].y1;
          hist[ch][b].y1 = acc[SB-1:0];
          s = acc[SB-1:0];
        end
      end
    end
    res.sample = s;
    return res;
  endfunction

  // Driver: offers queued samples, predicts each accepted transaction
  always @(posedge clk) begin : sample_driver
    eq_sample_t on_bus;
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        equalized_q.push_back(equalize_sample(on_bus));
        samples_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = samples_to_send.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.sample_in    <= on_bus.sample;
          in_bus.channel_in   <= on_bus.channel;
          in_bus.frame_end_in <= on_bus.frame_end;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random back-pressure, checks against model
  always @(posedge clk) begin : result_monitor
    eq_sample_t got;
    eq_sample_t want;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.sample    = out_bus.sample_out;
        got.channel   = out_bus.channel_out;
        got.frame_end = out_bus.frame_end_out;
        if (equalized_q.size() == 0) begin
          note_failure($sformatf("unexpected result sample=%0d ch=%0d end=%0d",
                                 $signed(got.sample), got.channel, got.frame_end));
        end else begin
          want = equalized_q.pop_front();
          if (got.sample !== want.sample || got.channel !== want.channel ||
              got.frame_end !== want.frame_end)
            note_failure($sformatf(
              "result %0d: expected sample=%0d ch=%0d end=%0d, got sample=%0d ch=%0d end=%0d",
              results_seen, $signed(want.sample), want.channel, want.frame_end,
              $signed(got.sample), got.channel, got.frame_end));
          if (got.frame_end === 1'b1) frame_ends++;
          results_seen++;
        end
      end
      out_bus.ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output stall so the block backs up and stalls its input
  initial begin
    wait (stall_armed);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // Register write; the model copy follows, with the block's masking
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      eqz_pkg::REG_BAND_ENABLE: band_en_m    = data[2:0];
      eqz_pkg::REG_BASS_FF:     ff_m[BASS]   = data[FF_BITS-1:0];
      eqz_pkg::REG_BASS_FB:     fb_m[BASS]   = data[FB_BITS-1:0];
      eqz_pkg::REG_MID_FF:      ff_m[MID]    = data[FF_BITS-1:0];
      eqz_pkg::REG_MID_FB:      fb_m[MID]    = data[FB_BITS-1:0];
      eqz_pkg::REG_TREBLE_FF:   ff_m[TREBLE] = data[FF_BITS-1:0];
      eqz_pkg::REG_TREBLE_FB:   fb_m[TREBLE] = data[FB_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_n++;
    @(negedge clk);
  endtask

  task automatic queue_sample(input logic signed [SB-1:0] s, input logic ch,
                              input logic fe);
    eq_sample_t item;
    item.sample    = s;
    item.channel   = ch;
    item.frame_end = fe;
    samples_to_send.push_back(item);
  endtask

  // Sender pauses until every expected result has come back
  task automatic wait_drained();
    while (samples_to_send.size() != 0 || in_bus.valid || equalized_q.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] junk_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // Wild picks use all 20 bits; tame picks stay within +/- span
  function automatic logic [COEF_BITS-1:0] pick_coef(bit wild, int unsigned span);
    if (wild) return COEF_BITS'($urandom);
    return COEF_BITS'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int unsigned sel = $urandom_range(99);
    if (sel < 10) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (sel < 35) return SB'(int'($urandom_range(8191)) - 4096);
    return SB'($urandom);
  endfunction

  task automatic program_bands(input logic [2:0] en, input bit wild);
    logic [CFG_DATA_W-1:0] en_word;
    en_word = junk_word();
    en_word[2:0] = en;
    write_reg(eqz_pkg::REG_BAND_ENABLE, en_word);
    write_reg(eqz_pkg::REG_BASS_FF, {pick_coef(wild, 65536), pick_coef(wild, 65536),
                                     pick_coef(wild, 65536)});
    write_reg(eqz_pkg::REG_BASS_FB, {20'($urandom), pick_coef(wild, 32768),
                                     pick_coef(wild, 32768)});
    write_reg(eqz_pkg::REG_MID_FF, {pick_coef(wild, 65536), pick_coef(wild, 65536),
                                    pick_coef(wild, 65536)});
    write_reg(eqz_pkg::REG_MID_FB, {20'($urandom), pick_coef(wild, 32768),
                                    pick_coef(wild, 32768)});
    write_reg(eqz_pkg::REG_TREBLE_FF, {pick_coef(wild, 65536), pick_coef(wild, 65536),
                                       pick_coef(wild, 65536)});
    write_reg(eqz_pkg::REG_TREBLE_FB, {20'($urandom), pick_coef(wild, 32768),
                                       pick_coef(wild, 32768)});
    write_reg(REG_SPARE, junk_word());
    end_writes();
  endtask

  // Stimulus sequence
  initial begin
    logic [2:0] en;
    in_bus.valid        = 1'b0;
    in_bus.sample_in    = '0;
    in_bus.channel_in   = 1'b0;
    in_bus.frame_end_in = 1'b0;
    out_bus.ready       = 1'b0;
    band_en_m = 3'b000;
    for (int b = 0; b < NUM_BANDS; b++) begin
      ff_m[b] = eqz_pkg::FF_RESET;
      fb_m[b] = eqz_pkg::FB_RESET;
      for (int c = 0; c < CHANNELS_DEF; c++) hist[c][b] = '{default: '0};
    end
    send_idle_pct = 37;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: every band bypassed, samples pass straight through
    queue_sample(SAMPLE_MAX, 1'b0, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1, 1'b1);
    queue_sample('0, 1'b0, 1'b1);
    queue_sample(SB'(-1), 1'b1, 1'b0);
    queue_sample(SB'(1), 1'b0, 1'b0);
    wait_drained();

    // Bass only at extreme gains: clipping both ways; junk above the
    // register widths and a write to the spare index must be ignored
    write_reg(eqz_pkg::REG_BAND_ENABLE, {{(CFG_DATA_W-3){1'b1}}, 3'b001});
    write_reg(eqz_pkg::REG_BASS_FF, {COEF_ZERO, COEF_MIN, COEF_MAX});
    write_reg(eqz_pkg::REG_BASS_FB, {{(COEF_BITS){1'b1}}, COEF_MIN, COEF_MAX});
    write_reg(REG_SPARE, '1);
    end_writes();
    queue_sample(SAMPLE_MAX, 1'b0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1, 1'b1);
    queue_sample('0, 1'b0, 1'b0);
    queue_sample(SB'(1), 1'b1, 1'b0);
    queue_sample(SB'(-1), 1'b0, 1'b1);
    wait_drained();

    // All three bands with extreme and all-ones coefficients
    write_reg(eqz_pkg::REG_MID_FF, {COEF_MIN, COEF_MAX, COEF_MIN});
    write_reg(eqz_pkg::REG_MID_FB, {{(COEF_BITS){1'b1}}, COEF_ZERO, COEF_ZERO});
    write_reg(eqz_pkg::REG_TREBLE_FF, {FF_BITS{1'b1}});
    write_reg(eqz_pkg::REG_TREBLE_FB, {COEF_MAX, COEF_LSB, {(COEF_BITS){1'b1}}});
    write_reg(eqz_pkg::REG_BAND_ENABLE, CFG_DATA_W'(3'b111));
    end_writes();
    queue_sample(SAMPLE_MAX, 1'b0, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1, 1'b1);
    wait_drained();

    // Treble only at gain one half: rounding of exact halves, both signs
    write_reg(eqz_pkg::REG_TREBLE_FF, {COEF_ZERO, COEF_ZERO, COEF_HALF});
    write_reg(eqz_pkg::REG_TREBLE_FB, '0);
    write_reg(eqz_pkg::REG_BAND_ENABLE, CFG_DATA_W'(3'b100));
    end_writes();
    queue_sample(SB'(1), 1'b0, 1'b0);
    queue_sample(SB'(-1), 1'b0, 1'b0);
    queue_sample(SB'(3), 1'b1, 1'b0);
    queue_sample(SB'(-3), 1'b1, 1'b1);
    wait_drained();

    // Random settings and streams; idle pattern changes every two phases
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 87 : 0;
      recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 37 : 0;
      en = (p == 0 || p == 4) ? 3'b111 : 3'($urandom_range(1, 7));
      program_bands(en, p[0]);
      for (int i = 0; i < PHASE_LEN; i++)
        queue_sample(pick_sample(), 1'($urandom_range(1)), $urandom_range(7) == 0);
      if (p == 4) stall_armed = 1'b1;
      wait_drained();
    end

    // Bass and mid coefficients back at their reset values; treble keeps its last setting
    write_reg(eqz_pkg::REG_BASS_FF, CFG_DATA_W'(COEF_ONE));
    write_reg(eqz_pkg::REG_BASS_FB, '0);
    write_reg(eqz_pkg::REG_MID_FF, CFG_DATA_W'(COEF_ONE));
    write_reg(eqz_pkg::REG_MID_FB, '0);
    end_writes();
    for (int i = 0; i < 8; i++)
      queue_sample(pick_sample(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (equalized_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", equalized_q.size()));
    $display("Checked %0d of %0d samples (%0d buffer ends, %0d clipped stages) over %0d settings.",
             results_seen, samples_sent, frame_ends, clipped_stages, settings_n);
    $display("Idle mixes on both sides, a %0d-cycle output stall; %0d failures.",
             STALL_CYCLES, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Timed out with %0d results still expected.", equalized_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/eqz_pkg.sv
rtl/eqz_in_if.sv
rtl/eqz_out_if.sv
rtl/eqz_hist_mem.sv
rtl/eqz_mac.sv
rtl/three_band_biquad_equalizer_unit.sv
verif/tb_three_band_biquad_equalizer_unit.sv
